FILE: design/fcs_pkg.sv
// Constants and sequencer codes for the filled circle span generator.
package fcs_pkg;

    localparam int ERR_BITS = 20;
    localparam int HW_BITS  = 17;
    localparam int RAD_BITS = 15;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    localparam int STATE_BITS = 2;
    localparam logic [STATE_BITS-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_BITS-1:0] ST_STEP = 2'd1;
    localparam logic [STATE_BITS-1:0] ST_EMIT = 2'd2;

    typedef logic [ERR_BITS-1:0] err_t;
    typedef logic [HW_BITS-1:0]  hw_t;

endpackage

FILE: design/filled_circle_span_generator.sv
// Filled circle span generator: midpoint scanline sequencer with one shared error-term adder.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_valid / s_ready  | func, center_x, center_y, radius
//  m_      | out       | m_valid / m_ready  | span_left/right, row_lower/upper, colour, last
//  cfg_    | in        | cfg_we             | fill colour (cfg_wdata)
//
// A start request writes the diameter span to the output register.
// An advance request takes k steps of 2x+1 on the error term for that row, then one step
// of -(2y - 1), and emits the row pair; the single error-term adder does one step per cycle.
// An advance while idle is taken and gives no result.
// Synchronous active-low reset clears the sequencer, the circle state and the output valid.
// New requests are taken only in idle and while the output register is free or draining;
// a stalled result holds the sequencer in its emit state.
module filled_circle_span_generator
    import fcs_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic signed [COORD_BITS-1:0] s_center_x,
    input  logic signed [COORD_BITS-1:0] s_center_y,
    input  logic [RAD_BITS-1:0]          s_radius,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS:0]   m_span_left,
    output logic signed [COORD_BITS:0]   m_span_right,
    output logic signed [COORD_BITS:0]   m_row_lower,
    output logic signed [COORD_BITS:0]   m_row_upper,
    output logic [7:0]                   m_span_color,
    output logic                         m_last
);

    localparam int OB = COORD_BITS + 1;

    logic [STATE_BITS-1:0] state_reg, state_next;
    logic                  busy_reg, busy_next;
    logic [COORD_BITS-1:0] center_col_reg, center_col_next;
    logic [COORD_BITS-1:0] center_row_reg, center_row_next;
    hw_t                   half_width_reg, half_width_next;
    logic [RAD_BITS-1:0]   row_offset_reg, row_offset_next;
    err_t                  error_reg, error_next;
    logic [7:0]            fill_color_reg, fill_color_next;

    logic                  m_valid_reg, m_valid_next;
    logic [OB-1:0]         left_reg, left_next;
    logic [OB-1:0]         right_reg, right_next;
    logic [OB-1:0]         lower_reg, lower_next;
    logic [OB-1:0]         upper_reg, upper_next;
    logic [7:0]            color_reg, color_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  accept;
    logic                  err_le0;
    err_t                  err_operand;
    err_t                  err_sum;
    logic                  use_input;
    logic [OB-1:0]         col_base, row_base, col_delta, row_delta;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // shared adder: err + 2x + 1 while not positive, else err - (2y - 1)
    // the second form is err + ~(2y) + 2
    assign err_le0     = error_reg[ERR_BITS-1] || (error_reg == '0);
    assign err_operand = err_le0 ? ERR_BITS'({half_width_reg, 1'b1})
                                 : ~ERR_BITS'({row_offset_reg, 1'b0});
    assign err_sum     = error_reg + err_operand + {{(ERR_BITS-2){1'b0}}, !err_le0, 1'b0};

    // span arithmetic, shared by the diameter and the row pairs
    assign use_input = (state_reg == ST_IDLE);
    assign col_base  = use_input ? OB'(s_center_x) : {center_col_reg[COORD_BITS-1], center_col_reg};
    assign row_base  = use_input ? OB'(s_center_y) : {center_row_reg[COORD_BITS-1], center_row_reg};
    assign col_delta = use_input ? OB'(s_radius) : OB'(half_width_reg);
    assign row_delta = use_input ? '0 : OB'(row_offset_reg);

    always_comb begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        center_col_next = center_col_reg;
        center_row_next = center_row_reg;
        half_width_next = half_width_reg;
        row_offset_next = row_offset_reg;
        error_next      = error_reg;
        fill_color_next = cfg_we ? cfg_wdata : fill_color_reg;

        m_valid_next = m_valid_reg && !m_ready;
        left_next    = left_reg;
        right_next   = right_reg;
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        color_next   = color_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_START) begin
                        center_col_next = s_center_x;
                        center_row_next = s_center_y;
                        half_width_next = '0;
                        row_offset_next = s_radius;
                        error_next      = '0 - ERR_BITS'(s_radius);
                        busy_next       = 1'b1;
                        m_valid_next    = 1'b1;
                        left_next       = col_base - col_delta;
                        right_next      = col_base + col_delta;
                        lower_next      = row_base + row_delta;
                        upper_next      = row_base - row_delta;
                        color_next      = fill_color_reg;
                        last_next       = 1'b0;
                    end else if (busy_reg) begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                error_next = err_sum;
                if (err_le0) begin
                    half_width_next = half_width_reg + 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    left_next    = col_base - col_delta;
                    right_next   = col_base + col_delta;
                    lower_next   = row_base + row_delta;
                    upper_next   = row_base - row_delta;
                    color_next   = fill_color_reg;
                    last_next    = (row_offset_reg == '0);
                    if (row_offset_reg == '0) begin
                        busy_next = 1'b0;
                    end else begin
                        row_offset_next = row_offset_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= 1'b0;
            center_col_reg <= '0;
            center_row_reg <= '0;
            half_width_reg <= '0;
            row_offset_reg <= '0;
            error_reg      <= '0;
            fill_color_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            center_col_reg <= center_col_next;
            center_row_reg <= center_row_next;
            half_width_reg <= half_width_next;
            row_offset_reg <= row_offset_next;
            error_reg      <= error_next;
            fill_color_reg <= fill_color_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        right_reg <= right_next;
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_span_left  = left_reg;
    assign m_span_right = right_reg;
    assign m_row_lower  = lower_reg;
    assign m_row_upper  = upper_reg;
    assign m_span_color = color_reg;
    assign m_last       = last_reg;

endmodule

FILE: dv/tb_filled_circle_span_generator.sv
// Self-checking testbench for filled_circle_span_generator: directed table, then random circles.
module tb_filled_circle_span_generator;
    import fcs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic signed [16:0] left;
        logic signed [16:0] right;
        logic signed [16:0] lower;
        logic signed [16:0] upper;
        logic [7:0]         color;
        logic               last;
    } span_t;

    // typed = expected span written out below rather than taken from the predictor
    typedef struct {
        logic               fn;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        r;
        bit                 typed;
        bit                 yields;
        logic signed [16:0] left;
        logic signed [16:0] right;
        logic signed [16:0] lower;
        logic signed [16:0] upper;
        logic               last;
    } dir_row_t;

    logic               aclk;
    logic               aresetn    = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [7:0]         cfg_wdata  = 8'h00;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic               s_func     = FUNC_ADVANCE;
    logic signed [15:0] s_center_x = '0;
    logic signed [15:0] s_center_y = '0;
    logic [14:0]        s_radius   = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic signed [16:0] m_span_left;
    logic signed [16:0] m_span_right;
    logic signed [16:0] m_row_lower;
    logic signed [16:0] m_row_upper;
    logic [7:0]         m_span_color;
    logic               m_last;

    // predictor state
    logic       circle_live = 1'b0;
    longint     ctr_col     = 0;
    longint     ctr_row     = 0;
    longint     half_w      = 0;
    longint     row_off     = 0;
    longint     err_acc     = 0;
    logic [7:0] fill_colour = 8'h00;

    span_t spans_due[$];
    int    errors        = 0;
    int    n_requests    = 0;
    int    n_spans_sent  = 0;
    int    n_spans_seen  = 0;
    int    n_circles     = 0;
    int    n_colours     = 0;
    int    widest_radius = 0;
    int    gap_next      = 0;
    int    n_cycles      = 0;
    bit    no_idle       = 1'b0;

    dir_row_t dir_tab [25] = '{
        '{FUNC_ADVANCE,      0,      0,     0, 1, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,        0,      0,     0, 1, 1,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 1, 1,     -1,     1,      0,      0, 1},
        '{FUNC_ADVANCE,      0,      0,     0, 1, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,    32767, -32768, 32767, 1, 1,      0, 65534, -32768, -32768, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,     -1,     -1, 32767, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,   -32768,  32767, 32767, 1, 1, -65535,    -1,  32767,  32767, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,      100,    -50,     1, 1, 1,     99,   101,    -50,    -50, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 1, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,       -1,     -1,     3, 1, 1,     -4,     2,     -1,     -1, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 1, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,    21845, -21846, 10922, 1, 1,  10923, 32767, -21846, -21846, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,   -21846,  21845, 21845, 1, 1, -43691,    -1,  21845,  21845, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0},
        '{FUNC_START,        0,      0,     5, 1, 1,     -5,     5,      0,      0, 0},
        '{FUNC_ADVANCE,      0,      0,     0, 0, 0,      0,     0,      0,      0, 0}
    };

    filled_circle_span_generator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_span_left  (m_span_left),
        .m_span_right (m_span_right),
        .m_row_lower  (m_row_lower),
        .m_row_upper  (m_row_upper),
        .m_span_color (m_span_color),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d spans outstanding", $time, spans_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic longint wrap_err(input longint v);
        logic signed [19:0] t;
        t = v[19:0];
        return longint'(t);
    endfunction

    function automatic span_t make_span(input longint l, input longint r, input longint lo,
                                        input longint up, input logic last);
        span_t t;
        t.left  = l[16:0];
        t.right = r[16:0];
        t.lower = lo[16:0];
        t.upper = up[16:0];
        t.color = fill_colour;
        t.last  = last;
        return t;
    endfunction

    // Midpoint row stepping; returns 1 when the request yields a span.
    function automatic bit predict_span(input logic fn, input logic signed [15:0] cx,
                                        input logic signed [15:0] cy, input logic [14:0] r,
                                        output span_t s);
        longint rr;
        bit     final_pair;
        rr = longint'(r);
        s  = '0;
        if (fn == FUNC_START) begin
            ctr_col     = longint'(cx);
            ctr_row     = longint'(cy);
            half_w      = 0;
            row_off     = rr;
            err_acc     = wrap_err(-rr);
            circle_live = 1'b1;
            s = make_span(ctr_col - rr, ctr_col + rr, ctr_row, ctr_row, 1'b0);
            return 1'b1;
        end
        if (!circle_live)
            return 1'b0;
        while (err_acc <= 0) begin
            err_acc = wrap_err(err_acc + 2 * half_w + 1);
            half_w  = (half_w + 1) & 64'h1_FFFF;
        end
        err_acc    = wrap_err(err_acc - (2 * row_off - 1));
        final_pair = (row_off == 0);
        s = make_span(ctr_col - half_w, ctr_col + half_w, ctr_row + row_off,
                      ctr_row - row_off, final_pair);
        if (final_pair)
            circle_live = 1'b0;
        else
            row_off--;
        return 1'b1;
    endfunction

    task automatic send_request(input logic fn, input logic signed [15:0] cx,
                                input logic signed [15:0] cy, input logic [14:0] r,
                                input bit typed, input bit typed_yields, input span_t typed_span);
        span_t s;
        bit    yields;
        if (gap_next > 0)
            repeat (gap_next) @(posedge aclk);
        s_valid    <= 1'b1;
        s_func     <= fn;
        s_center_x <= cx;
        s_center_y <= cy;
        s_radius   <= r;
        do @(posedge aclk); while (s_ready !== 1'b1);
        yields = predict_span(fn, cx, cy, r, s);
        if (typed) begin
            yields = typed_yields;
            s      = typed_span;
        end
        if (yields) begin
            spans_due.push_back(s);
            n_spans_sent++;
        end
        if (fn == FUNC_START && int'(r) > widest_radius)
            widest_radius = int'(r);
        n_requests++;
        gap_next = draw_wait();
        // keep valid up when the next request follows straight on
        if (gap_next > 0)
            s_valid <= 1'b0;
    endtask

    task automatic random_start(input logic [14:0] r);
        send_request(FUNC_START, 16'($urandom), 16'($urandom), r, 1'b0, 1'b0, '0);
    endtask

    task automatic random_advance();
        send_request(FUNC_ADVANCE, 16'($urandom), 16'($urandom), 15'($urandom),
                     1'b0, 1'b0, '0);
    endtask

    // Hold the sender until every span is back, then let a stray idle advance settle.
    task automatic drain_spans();
        if (gap_next == 0)
            s_valid <= 1'b0;
        while (spans_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_fill_colour(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        fill_colour  = v;
        n_colours++;
    endtask

    task automatic check_field(input string f, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, f, want, got);
            errors++;
        end
    endtask

    // result side
    initial begin
        span_t want;
        int    stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            n_spans_seen++;
            if (spans_due.size() == 0) begin
                $display("%0t: span with none expected, expected nothing, got %0d..%0d",
                         $time, m_span_left, m_span_right);
                errors++;
            end else begin
                want = spans_due.pop_front();
                check_field("span_left",  32'(want.left),  32'(m_span_left));
                check_field("span_right", 32'(want.right), 32'(m_span_right));
                check_field("row_lower",  32'(want.lower), 32'(m_row_lower));
                check_field("row_upper",  32'(want.upper), 32'(m_row_upper));
                check_field("span_color", 32'(want.color), 32'(m_span_color));
                check_field("last",       32'(want.last),  32'(m_last));
                if (want.last)
                    n_circles++;
            end
        end
    end

    // request side
    initial begin
        span_t       ts;
        logic [14:0] rad;
        int          pick;
        int          n_adv;
        bit          big;
        logic [7:0]  colours [4];

        colours[0] = 8'h00;
        colours[1] = 8'hFF;
        colours[2] = 8'($urandom);
        colours[3] = 8'($urandom);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_fill_colour(8'hA5);

        foreach (dir_tab[i]) begin
            ts.left  = dir_tab[i].left;
            ts.right = dir_tab[i].right;
            ts.lower = dir_tab[i].lower;
            ts.upper = dir_tab[i].upper;
            ts.color = fill_colour;
            ts.last  = dir_tab[i].last;
            send_request(dir_tab[i].fn, dir_tab[i].cx, dir_tab[i].cy, dir_tab[i].r,
                         dir_tab[i].typed, dir_tab[i].yields, ts);
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_spans();
            write_fill_colour(colours[ph]);
            no_idle = (ph == 2);
            while (n_spans_sent < 25 + 225 * (ph + 1)) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // whole circle; big radii are cut short by the next start
                    big   = ($urandom_range(0, 9) == 0);
                    rad   = big ? 15'($urandom) : 15'($urandom_range(0, 24));
                    n_adv = big ? $urandom_range(0, 6) : int'(rad) + 1;
                    random_start(rad);
                    repeat (n_adv) random_advance();
                    if (!big && $urandom_range(0, 4) == 0)
                        random_advance();
                end else if (pick < 85) begin
                    rad = 15'($urandom_range(2, 24));
                    random_start(rad);
                    repeat ($urandom_range(0, int'(rad))) random_advance();
                end else begin
                    send_request(logic'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                 15'($urandom), 1'b0, 1'b0, '0);
                end
            end
        end

        drain_spans();
        $display("Run covered %0d requests and %0d spans, %0d circles down to their last pair.",
                 n_requests, n_spans_seen, n_circles);
        $display("Fill colour set %0d times; widest radius started was %0d.",
                 n_colours, widest_radius);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
design/fcs_pkg.sv
design/filled_circle_span_generator.sv
dv/tb_filled_circle_span_generator.sv
